[rtl/core/kdo_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the direction orthogonalizer.
// No dependencies; every other file but kdo_if imports this package.
package kdo_pkg;

	localparam int MAX_LEN   = 4096;
	localparam int MAX_DIR   = 16;
	localparam int FRAC_BITS = 16;

	localparam int IDX_W  = $clog2(MAX_LEN);
	localparam int DIR_W  = $clog2(MAX_DIR);
	localparam int CNT_W  = $clog2(MAX_DIR + 1);
	localparam int LEN_W  = 13;
	localparam int CAP_W  = 5;
	localparam int ADDR_W = DIR_W + IDX_W;
	localparam int MP_W   = 51;
	localparam int SUM_W  = 58;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_DOT   = 2'd1,
		CMD_APPLY = 2'd2
	} cmd_t;

	localparam logic REG_VECTOR_LENGTH  = 1'b0;
	localparam logic REG_MAX_DIRECTIONS = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_NORM = 2'd1;
	localparam logic [1:0] ST_SAT       = 2'd2;

	typedef struct packed {
		cmd_t               kind;
		logic               first;
		logic               last;
		logic [IDX_W-1:0]   idx;
		logic [DIR_W-1:0]   slot;
		logic [CNT_W-1:0]   cnt;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
		logic signed [31:0] norm_re;
		logic signed [31:0] norm_im;
	} op_t;

	// round pa +/- pb to FRAC_BITS, halves away from zero
	function automatic logic signed [MP_W-1:0] round_pair(logic signed [63:0] pa,
			logic signed [63:0] pb, logic sub);
		logic signed [65:0] s;
		logic [65:0] m;
		logic [MP_W-2:0] q;
		s = sub ? (66'(pa) - 66'(pb)) : (66'(pa) + 66'(pb));
		m = s[65] ? 66'(-s) : 66'(s);
		q = (MP_W-1)'((m + (66'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
		round_pair = s[65] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	function automatic logic sat_ovf(logic signed [SUM_W-1:0] v);
		sat_ovf = (v > SUM_W'(64'sd2147483647)) || (v < -(SUM_W'(64'sd2147483648)));
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(64'sd2147483647))
			sat32 = 32'sh7FFFFFFF;
		else if (v < -(SUM_W'(64'sd2147483648)))
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction

	function automatic logic [1:0] raise(logic [1:0] st, logic [1:0] c);
		raise = (c > st) ? c : st;
	endfunction

endpackage

[rtl/core/kdo_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
interface kdo_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] a_re;
	logic [31:0] a_im;
	logic [31:0] b_re;
	logic [31:0] b_im;
	logic [31:0] norm_re;
	logic [31:0] norm_im;
	modport source (output valid, command, a_re, a_im, b_re, b_im, norm_re, norm_im,
		input ready);
	modport sink (input valid, command, a_re, a_im, b_re, b_im, norm_re, norm_im,
		output ready);
endinterface

interface kdo_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] c_re;
	logic [31:0] c_im;
	logic [31:0] d_re;
	logic [31:0] d_im;
	logic        last_element;
	logic [1:0]  status;
	modport source (output valid, c_re, c_im, d_re, d_im, last_element, status,
		input ready);
	modport sink (input valid, c_re, c_im, d_re, d_im, last_element, status,
		output ready);
endinterface

[rtl/core/krylov_direction_orthogonalizer_unit.sv]
`timescale 1ns / 1ps
// Top level of the complex direction orthogonalizer: front end, queue, back end.
// Depends on kdo_pkg, kdo_if, kdo_front, kdo_queue and kdo_back.

// Items are taken one at a time by a single shared pair of 32x32 multipliers and one read
// port on each direction store. Dot and apply elements take longer the more stored directions
// take part, and an apply element may also wait for the result register. The last element of
// a dot pass also runs the bit-serial divider, which forms both parts of each coefficient of a
// direction with a nonzero norm at one bit a cycle. A two-entry queue lets the front end keep
// taking items while the back end works, until the queue is full.
module krylov_direction_orthogonalizer_unit import kdo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LEN_W-1:0] cfg_wdata,
	kdo_in_if.sink           in_ch,
	kdo_out_if.source        out_ch
);

	logic push, full, pop, empty;
	op_t  push_op, head;

	kdo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.q_full    (full),
		.push      (push),
		.push_op   (push_op)
	);

	kdo_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	kdo_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (empty),
		.head    (head),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

[rtl/core/kdo_front.sv]
`timescale 1ns / 1ps
// Front end: configuration registers, pass tracking and item classification.
// Depends on kdo_pkg and kdo_in_if.
module kdo_front import kdo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LEN_W-1:0] cfg_wdata,
	kdo_in_if.sink           in_ch,
	input  logic             q_full,
	output logic             push,
	output op_t              push_op
);

	logic [LEN_W-1:0] len_q;
	logic [CAP_W-1:0] cap_q;
	logic [IDX_W-1:0] ec_q;
	logic [1:0]       pc_q;
	logic [CNT_W-1:0] sc_q;

	logic [LEN_W-1:0] len_eff;
	logic [CAP_W-1:0] cap_eff;
	logic [IDX_W-1:0] ec_eff;
	logic             last;
	logic             first;
	logic             known;
	logic             xfer;
	logic [CNT_W-1:0] sc_base;
	logic [CNT_W-1:0] sc_prev;

	assign in_ch.ready = !q_full;
	assign xfer = in_ch.valid && in_ch.ready;

	always_comb begin
		len_eff = (len_q == '0) ? LEN_W'(1) :
			((len_q > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_q);
		cap_eff = (cap_q == '0) ? CAP_W'(1) :
			((cap_q > CAP_W'(MAX_DIR)) ? CAP_W'(MAX_DIR) : cap_q);
		ec_eff  = (ec_q != '0 && in_ch.command != pc_q) ? '0 : ec_q;
		first   = (ec_eff == '0);
		last    = (LEN_W'(ec_eff) + LEN_W'(1)) >= len_eff;
		sc_base = (sc_q >= CNT_W'(cap_eff)) ? CNT_W'(cap_eff - 1'b1) : sc_q;
		sc_prev = (sc_q == '0) ? '0 : sc_q - 1'b1;
		unique case (in_ch.command)
			CMD_ADD, CMD_DOT, CMD_APPLY: known = 1'b1;
			default:                     known = 1'b0;
		endcase
		push = xfer && known;
		push_op.kind    = cmd_t'(in_ch.command);
		push_op.first   = first;
		push_op.last    = last;
		push_op.idx     = ec_eff;
		push_op.slot    = first ? sc_base[DIR_W-1:0] : sc_prev[DIR_W-1:0];
		push_op.cnt     = (sc_q < CNT_W'(cap_eff)) ? sc_q : CNT_W'(cap_eff);
		push_op.a_re    = in_ch.a_re;
		push_op.a_im    = in_ch.a_im;
		push_op.b_re    = in_ch.b_re;
		push_op.b_im    = in_ch.b_im;
		push_op.norm_re = in_ch.norm_re;
		push_op.norm_im = in_ch.norm_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(MAX_LEN);
			cap_q <= CAP_W'(MAX_DIR);
			ec_q  <= '0;
			pc_q  <= CMD_ADD;
			sc_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_VECTOR_LENGTH:  len_q <= cfg_wdata;
					REG_MAX_DIRECTIONS: cap_q <= cfg_wdata[CAP_W-1:0];
					default: ;
				endcase
			end
			if (push) begin
				pc_q <= in_ch.command;
				ec_q <= last ? '0 : ec_eff + 1'b1;
				if (in_ch.command == CMD_ADD && first)
					sc_q <= sc_base + 1'b1;
			end
		end
	end

endmodule

[rtl/core/kdo_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue of classified items between front and back end.
// Depends on kdo_pkg.
module kdo_queue import kdo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  head,
	output logic empty
);

	op_t        ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[rtl/core/kdo_back.sv]
`timescale 1ns / 1ps
// Back end: direction stores, multiply-accumulate sequencer, bit-serial divider, result register.
// Depends on kdo_pkg and kdo_out_if.
module kdo_back import kdo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_empty,
	input  op_t      head,
	output logic     pop,
	kdo_out_if.source out_ch
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_ADD  = 11'b00000000010,
		S_RD   = 11'b00000000100,
		S_MUL  = 11'b00000001000,
		S_SUM  = 11'b00000010000,
		S_OUT  = 11'b00000100000,
		S_FIN  = 11'b00001000000,
		S_FMUL = 11'b00010000000,
		S_FSUM = 11'b00100000000,
		S_DIV  = 11'b01000000000,
		S_DRES = 11'b10000000000
	} state_t;

	localparam int DIV_STEPS = 64 + FRAC_BITS;

	state_t state_q;
	op_t    op_q;

	logic [63:0] dir_mem [MAX_DIR*MAX_LEN];
	logic [63:0] img_mem [MAX_DIR*MAX_LEN];
	logic [63:0] rd_dir_q;
	logic [63:0] rd_img_q;

	logic signed [31:0] nrm_re [MAX_DIR];
	logic signed [31:0] nrm_im [MAX_DIR];
	logic signed [31:0] y_re   [MAX_DIR];
	logic signed [31:0] y_im   [MAX_DIR];

	logic [CNT_W-1:0] j_q;
	logic [1:0]       k_q;
	logic [1:0]       st_q;
	logic signed [63:0] pa_q, pb_q;
	logic signed [SUM_W-1:0] sum_q [4];

	logic        nre_neg_q, nim_neg_q, comp_q, big_q;
	logic [63:0] nre_mag_q, nim_mag_q, den_q, num_q, rem_q;
	logic [32:0] quo_q;
	logic [$clog2(DIV_STEPS)-1:0] dcnt_q;
	logic signed [31:0] yre_q;

	logic        oval_q, olast_q;
	logic [31:0] oc_re_q, oc_im_q, od_re_q, od_im_q;
	logic [1:0]  ost_q;

	logic [DIR_W-1:0] jj;
	logic signed [31:0] x1, m1, x2, m2;
	logic sub;
	logic signed [MP_W-1:0] mp;
	logic signed [SUM_W-1:0] dsum;
	logic signed [64:0] fsum;
	logic [64:0] rem_sh;
	logic ge;
	logic [63:0] rem_n;
	logic [32:0] quo_n;
	logic [33:0] qr;
	logic rnd, dneg, dsat;
	logic signed [31:0] yv;
	logic out_load, osat;

	assign jj = j_q[DIR_W-1:0];
	assign pop = (state_q == S_IDLE) && !q_empty;
	assign out_load = (state_q == S_OUT) && (!oval_q || out_ch.ready);

	always_comb begin
		x1 = '0; m1 = '0; x2 = '0; m2 = '0; sub = 1'b0;
		if (state_q == S_FMUL || state_q == S_FSUM) begin
			case (k_q)
				2'd0: begin x1 = y_re[jj]; m1 = nrm_re[jj]; x2 = y_im[jj]; m2 = nrm_im[jj]; end
				2'd1: begin x1 = y_im[jj]; m1 = nrm_re[jj]; x2 = y_re[jj]; m2 = nrm_im[jj]; end
				default: begin
					x1 = nrm_re[jj]; m1 = nrm_re[jj]; x2 = nrm_im[jj]; m2 = nrm_im[jj];
				end
			endcase
		end else if (op_q.kind == CMD_DOT) begin
			x1 = rd_img_q[63:32];
			x2 = rd_img_q[31:0];
			m1 = (k_q == 2'd0) ? op_q.a_re : op_q.a_im;
			m2 = (k_q == 2'd0) ? op_q.a_im : op_q.a_re;
			sub = (k_q == 2'd1);
		end else begin
			x1 = k_q[1] ? rd_img_q[63:32] : rd_dir_q[63:32];
			x2 = k_q[1] ? rd_img_q[31:0] : rd_dir_q[31:0];
			m1 = k_q[0] ? y_im[jj] : y_re[jj];
			m2 = k_q[0] ? y_re[jj] : y_im[jj];
			sub = !k_q[0];
		end
		mp   = round_pair(pa_q, pb_q, sub);
		dsum = SUM_W'((k_q == 2'd0) ? y_re[jj] : y_im[jj]) + SUM_W'(mp);
		fsum = (k_q == 2'd1) ? (65'(pa_q) - 65'(pb_q)) : (65'(pa_q) + 65'(pb_q));
		rem_sh = {rem_q, num_q[63]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_n  = ge ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
		quo_n  = big_q ? quo_q : {quo_q[31:0], ge};
		rnd    = !big_q && (rem_q >= den_q - rem_q);
		qr     = 34'(quo_q) + 34'(rnd);
		dneg   = comp_q ? nim_neg_q : nre_neg_q;
		if (dneg) begin
			dsat = big_q || (qr > 34'h07FFFFFFF);
			yv   = dsat ? 32'sh7FFFFFFF : qr[31:0];
		end else begin
			dsat = big_q || (qr > 34'h080000000);
			yv   = dsat ? 32'sh80000000 : 32'(34'd0 - qr);
		end
		osat = sat_ovf(sum_q[0]) || sat_ovf(sum_q[1]) || sat_ovf(sum_q[2]) ||
			sat_ovf(sum_q[3]);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ADD) begin
			dir_mem[{op_q.slot, op_q.idx}] <= {op_q.a_re, op_q.a_im};
			img_mem[{op_q.slot, op_q.idx}] <= {op_q.b_re, op_q.b_im};
			if (op_q.first) begin
				nrm_re[op_q.slot] <= op_q.norm_re;
				nrm_im[op_q.slot] <= op_q.norm_im;
			end
		end
		if (state_q == S_RD) begin
			rd_dir_q <= dir_mem[{jj, op_q.idx}];
			rd_img_q <= img_mem[{jj, op_q.idx}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= '0;
			j_q     <= '0;
			k_q     <= '0;
			st_q    <= ST_OK;
			oval_q  <= 1'b0;
			comp_q  <= 1'b0;
			big_q   <= 1'b0;
			dcnt_q  <= '0;
			for (int e = 0; e < MAX_DIR; e++) begin
				y_re[e] <= '0;
				y_im[e] <= '0;
			end
		end else begin
			if (out_ch.ready && !out_load)
				oval_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						op_q <= head;
						j_q  <= '0;
						k_q  <= '0;
						sum_q[0] <= SUM_W'(head.a_re);
						sum_q[1] <= SUM_W'(head.a_im);
						sum_q[2] <= SUM_W'(head.b_re);
						sum_q[3] <= SUM_W'(head.b_im);
						if (head.kind == CMD_DOT && head.first) begin
							st_q <= ST_OK;
							for (int e = 0; e < MAX_DIR; e++) begin
								y_re[e] <= '0;
								y_im[e] <= '0;
							end
						end
						if (head.kind == CMD_ADD)
							state_q <= S_ADD;
						else if (head.cnt != '0)
							state_q <= S_RD;
						else if (head.kind == CMD_APPLY)
							state_q <= S_OUT;
						else
							state_q <= head.last ? S_FIN : S_IDLE;
					end
				end
				S_ADD: state_q <= S_IDLE;
				S_RD: begin
					k_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					pa_q    <= x1 * m1;
					pb_q    <= x2 * m2;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (op_q.kind == CMD_DOT) begin
						if (k_q == 2'd0)
							y_re[jj] <= sat32(dsum);
						else
							y_im[jj] <= sat32(dsum);
						if (sat_ovf(dsum))
							st_q <= raise(st_q, ST_SAT);
					end else begin
						sum_q[k_q] <= sum_q[k_q] + SUM_W'(mp);
					end
					if ((op_q.kind == CMD_DOT && k_q == 2'd1) || k_q == 2'd3) begin
						if (j_q + 1'b1 < op_q.cnt) begin
							j_q     <= j_q + 1'b1;
							state_q <= S_RD;
						end else if (op_q.kind == CMD_APPLY) begin
							state_q <= S_OUT;
						end else begin
							j_q     <= '0;
							state_q <= op_q.last ? S_FIN : S_IDLE;
						end
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (out_load) begin
						oval_q  <= 1'b1;
						oc_re_q <= sat32(sum_q[0]);
						oc_im_q <= sat32(sum_q[1]);
						od_re_q <= sat32(sum_q[2]);
						od_im_q <= sat32(sum_q[3]);
						olast_q <= op_q.last;
						ost_q   <= osat ? raise(st_q, ST_SAT) : st_q;
						if (osat)
							st_q <= raise(st_q, ST_SAT);
						state_q <= S_IDLE;
					end
				end
				S_FIN: begin
					k_q <= '0;
					if (j_q >= op_q.cnt) begin
						for (int e = 0; e < MAX_DIR; e++) begin
							if (CNT_W'(e) >= op_q.cnt) begin
								y_re[e] <= '0;
								y_im[e] <= '0;
							end
						end
						state_q <= S_IDLE;
					end else if (nrm_re[jj] == '0 && nrm_im[jj] == '0) begin
						y_re[jj] <= '0;
						y_im[jj] <= '0;
						st_q     <= raise(st_q, ST_ZERO_NORM);
						j_q      <= j_q + 1'b1;
					end else begin
						state_q <= S_FMUL;
					end
				end
				S_FMUL: begin
					pa_q    <= x1 * m1;
					pb_q    <= x2 * m2;
					state_q <= S_FSUM;
				end
				S_FSUM: begin
					case (k_q)
						2'd0: begin
							nre_neg_q <= fsum[64];
							nre_mag_q <= fsum[64] ? 64'(-fsum) : fsum[63:0];
						end
						2'd1: begin
							nim_neg_q <= fsum[64];
							nim_mag_q <= fsum[64] ? 64'(-fsum) : fsum[63:0];
						end
						default: den_q <= fsum[63:0];
					endcase
					if (k_q == 2'd2) begin
						comp_q  <= 1'b0;
						num_q   <= nre_mag_q;
						rem_q   <= '0;
						quo_q   <= '0;
						big_q   <= 1'b0;
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_FMUL;
					end
				end
				S_DIV: begin
					num_q  <= num_q << 1;
					rem_q  <= rem_n;
					quo_q  <= quo_n;
					big_q  <= big_q | quo_n[32];
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == ($clog2(DIV_STEPS))'(DIV_STEPS - 1))
						state_q <= S_DRES;
				end
				S_DRES: begin
					if (dsat)
						st_q <= raise(st_q, ST_SAT);
					if (!comp_q) begin
						yre_q   <= yv;
						comp_q  <= 1'b1;
						num_q   <= nim_mag_q;
						rem_q   <= '0;
						quo_q   <= '0;
						big_q   <= 1'b0;
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end else begin
						y_re[jj] <= yre_q;
						y_im[jj] <= yv;
						j_q      <= j_q + 1'b1;
						state_q  <= S_FIN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid        = oval_q;
	assign out_ch.c_re         = oc_re_q;
	assign out_ch.c_im         = oc_im_q;
	assign out_ch.d_re         = od_re_q;
	assign out_ch.d_im         = od_im_q;
	assign out_ch.last_element = olast_q;
	assign out_ch.status       = ost_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for krylov_direction_orthogonalizer_unit: a queued driver, a monitor
// and a bit-exact predictor of the complex direction store in Q16.16 fixed point.
// Depends on kdo_pkg, kdo_if and the unit itself.
module tb_top;
	import kdo_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int SETTLE_CYCLES = 4000;
	localparam logic signed [65:0] Q_MAX = 66'sd2147483647;
	localparam logic signed [65:0] Q_MIN = -66'sd2147483648;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [31:0] a_re, a_im, b_re, b_im, n_re, n_im;
	} in_item_t;

	typedef struct {
		logic [31:0] c_re, c_im, d_re, d_im;
		logic        last;
		logic [1:0]  status;
	} res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [LEN_W-1:0] cfg_wdata;

	kdo_in_if  in_ch ();
	kdo_out_if out_ch ();

	krylov_direction_orthogonalizer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// predictor state
	logic signed [31:0] dir_re [0:65535];
	logic signed [31:0] dir_im [0:65535];
	logic signed [31:0] img_re [0:65535];
	logic signed [31:0] img_im [0:65535];
	logic signed [31:0] nrm_re [0:15];
	logic signed [31:0] nrm_im [0:15];
	logic signed [31:0] coef_re [0:15];
	logic signed [31:0] coef_im [0:15];
	int unsigned stored;
	int unsigned elem_cnt;
	logic [1:0]  sticky;
	logic [1:0]  pass_cmd;
	int unsigned vlen;
	int unsigned maxdir;

	in_item_t item_queue [$];
	res_t     pending_results [$];
	in_item_t cur_item;
	res_t     drv_res;
	res_t     want;
	int       send_gap;
	int       recv_stall;
	bit       quiet;
	int       errors;
	int       items_sent;
	int       results_checked;
	int       settings_used;

	function automatic void raise_st(logic [1:0] c);
		if (c > sticky)
			sticky = c;
	endfunction

	function automatic logic signed [31:0] clip32(logic signed [65:0] v);
		if (v > Q_MAX) begin
			raise_st(ST_SAT);
			return 32'sh7FFFFFFF;
		end
		if (v < Q_MIN) begin
			raise_st(ST_SAT);
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// round a*b +/- c*d to the fraction width, halves away from zero
	function automatic logic signed [63:0] rmul(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic signed [31:0] d, bit sub);
		logic signed [65:0] s;
		logic [65:0] m;
		logic [65:0] q;
		s = sub ? 66'(a) * 66'(b) - 66'(c) * 66'(d) : 66'(a) * 66'(b) + 66'(c) * 66'(d);
		m = s[65] ? -s : s;
		q = (m + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return s[65] ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	// -(num / den), rounded to nearest and saturated
	function automatic logic signed [31:0] neg_quot(logic signed [65:0] num, logic [65:0] den);
		logic [65:0]  mag;
		logic [127:0] n;
		logic [127:0] q;
		logic [127:0] r;
		mag = num[65] ? -num : num;
		n = 128'(mag) << FRAC_BITS;
		q = n / 128'(den);
		r = n % 128'(den);
		if (q <= 128'hFFFFFFFF && r >= 128'(den) - r)
			q++;
		if (q > 128'h200000000)
			q = 128'h200000000;
		return num[65] ? clip32($signed(q[65:0])) : clip32(-$signed(q[65:0]));
	endfunction

	function automatic void finish_dot(int unsigned cnt);
		logic signed [65:0] num_r, num_i;
		logic [65:0] den;
		for (int j = 0; j < MAX_DIR; j++) begin
			num_r = 66'(coef_re[j]) * 66'(nrm_re[j]) + 66'(coef_im[j]) * 66'(nrm_im[j]);
			num_i = 66'(coef_im[j]) * 66'(nrm_re[j]) - 66'(coef_re[j]) * 66'(nrm_im[j]);
			den = 66'(nrm_re[j]) * 66'(nrm_re[j]) + 66'(nrm_im[j]) * 66'(nrm_im[j]);
			if (j < cnt && den == 0) begin
				raise_st(ST_ZERO_NORM);
				coef_re[j] = '0;
				coef_im[j] = '0;
			end else if (j < cnt) begin
				coef_re[j] = neg_quot(num_r, den);
				coef_im[j] = neg_quot(num_i, den);
			end else begin
				coef_re[j] = '0;
				coef_im[j] = '0;
			end
		end
	endfunction

	function automatic bit orth_step(input in_item_t it, output res_t r);
		int unsigned len, cap, cnt, i;
		bit lastel;
		logic [15:0] adr;
		logic signed [65:0] sr, si, tr, ti;
		r = '{default: '0};
		if (it.cmd == CMD_NOP)
			return 0;
		len = vlen == 0 ? 1 : (vlen > MAX_LEN ? MAX_LEN : vlen);
		cap = maxdir == 0 ? 1 : (maxdir > MAX_DIR ? MAX_DIR : maxdir);
		if (elem_cnt != 0 && it.cmd != pass_cmd)
			elem_cnt = 0;
		pass_cmd = it.cmd;
		i = elem_cnt % MAX_LEN;
		lastel = elem_cnt + 1 >= len;
		cnt = stored < cap ? stored : cap;
		orth_step = 0;
		case (it.cmd)
			CMD_ADD: begin
				if (elem_cnt == 0) begin
					if (stored >= cap)
						stored = cap - 1;
					nrm_re[stored] = it.n_re;
					nrm_im[stored] = it.n_im;
					stored++;
				end
				adr = {4'(stored - 1), 12'(i)};
				dir_re[adr] = it.a_re;
				dir_im[adr] = it.a_im;
				img_re[adr] = it.b_re;
				img_im[adr] = it.b_im;
			end
			CMD_DOT: begin
				if (elem_cnt == 0) begin
					for (int j = 0; j < MAX_DIR; j++) begin
						coef_re[j] = '0;
						coef_im[j] = '0;
					end
					sticky = ST_OK;
				end
				for (int j = 0; j < cnt; j++) begin
					adr = {4'(j), 12'(i)};
					coef_re[j] = clip32(66'(coef_re[j])
						+ 66'(rmul(img_re[adr], it.a_re, img_im[adr], it.a_im, 0)));
					coef_im[j] = clip32(66'(coef_im[j])
						+ 66'(rmul(img_re[adr], it.a_im, img_im[adr], it.a_re, 1)));
				end
				if (lastel)
					finish_dot(cnt);
			end
			default: begin
				sr = it.a_re;
				si = it.a_im;
				tr = it.b_re;
				ti = it.b_im;
				for (int j = 0; j < cnt; j++) begin
					adr = {4'(j), 12'(i)};
					sr += rmul(dir_re[adr], coef_re[j], dir_im[adr], coef_im[j], 1);
					si += rmul(dir_re[adr], coef_im[j], dir_im[adr], coef_re[j], 0);
					tr += rmul(img_re[adr], coef_re[j], img_im[adr], coef_im[j], 1);
					ti += rmul(img_re[adr], coef_im[j], img_im[adr], coef_re[j], 0);
				end
				r.c_re = clip32(sr);
				r.c_im = clip32(si);
				r.d_re = clip32(tr);
				r.d_im = clip32(ti);
				r.last = lastel;
				r.status = sticky;
				orth_step = 1;
			end
		endcase
		elem_cnt = lastel ? 0 : elem_cnt + 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.command <= CMD_NOP;
			in_ch.a_re <= '0;
			in_ch.a_im <= '0;
			in_ch.b_re <= '0;
			in_ch.b_im <= '0;
			in_ch.norm_re <= '0;
			in_ch.norm_im <= '0;
			send_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				items_sent++;
				if (orth_step(cur_item, drv_res))
					pending_results.push_back(drv_res);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (item_queue.size() != 0) begin
					cur_item = item_queue.pop_front();
					in_ch.command <= cur_item.cmd;
					in_ch.a_re <= cur_item.a_re;
					in_ch.a_im <= cur_item.a_im;
					in_ch.b_re <= cur_item.b_re;
					in_ch.b_im <= cur_item.b_im;
					in_ch.norm_re <= cur_item.n_re;
					in_ch.norm_im <= cur_item.n_im;
					in_ch.valid <= 1'b1;
					if (!quiet && $urandom_range(0, 11) == 0)
						send_gap <= $urandom_range(1, 17);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic chk(string nm, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s expected %0d got %0d", nm, $signed(e), $signed(a));
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					chk("c_re", want.c_re, out_ch.c_re);
					chk("c_im", want.c_im, out_ch.c_im);
					chk("d_re", want.d_re, out_ch.d_re);
					chk("d_im", want.d_im, out_ch.d_im);
					chk("last_element", 32'(want.last), 32'(out_ch.last_element));
					chk("status", 32'(want.status), 32'(out_ch.status));
				end
			end
			if (recv_stall != 0) begin
				recv_stall <= recv_stall - 1;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				recv_stall <= $urandom_range(0, 16);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [31:0] rq();
		case ($urandom_range(0, 15))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 32'sh0;
			3: return 32'sh10000;
			4: return -32'sh10000;
			5, 6: return $urandom;
			default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
		endcase
	endfunction

	function automatic logic [63:0] norm_pair();
		if ($urandom_range(0, 7) == 0)
			return 64'd0;
		return {rq(), rq()};
	endfunction

	function automatic void push(logic [1:0] c, logic signed [31:0] ar, logic signed [31:0] ai,
			logic signed [31:0] br, logic signed [31:0] bi, logic [63:0] nrm);
		in_item_t it;
		it.cmd = c;
		it.a_re = ar;
		it.a_im = ai;
		it.b_re = br;
		it.b_im = bi;
		it.n_re = nrm[63:32];
		it.n_im = nrm[31:0];
		item_queue.push_back(it);
	endfunction

	function automatic void queue_pass(logic [1:0] c, int n, logic [63:0] nrm);
		for (int k = 0; k < n; k++)
			push(c, rq(), rq(), rq(), rq(), k == 0 ? nrm : {rq(), rq()});
	endfunction

	task automatic settle();
		@(negedge clk);
		while (item_queue.size() != 0 || in_ch.valid)
			@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_cfg(logic idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= LEN_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_VECTOR_LENGTH)
			vlen = val & 13'h1FFF;
		else
			maxdir = val & 5'h1F;
		settings_used++;
	endtask

	initial begin
		int eff;
		int budget;
		int k;
		logic [1:0] c1, c2;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		stored = 0;
		elem_cnt = 0;
		sticky = ST_OK;
		pass_cmd = CMD_ADD;
		vlen = MAX_LEN;
		maxdir = MAX_DIR;
		quiet = 0;
		errors = 0;
		items_sent = 0;
		results_checked = 0;
		settings_used = 0;
		for (int j = 0; j < MAX_DIR; j++) begin
			coef_re[j] = '0;
			coef_im[j] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// clamped length on an empty store; apply passes a and b straight through
		set_cfg(REG_VECTOR_LENGTH, 8191);
		set_cfg(REG_MAX_DIRECTIONS, 1);
		push(CMD_APPLY, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 64'd0);
		push(CMD_APPLY, 32'sh0, 32'sh7FFFFFFF, 32'sh0, 32'sh80000000, {64{1'b1}});
		push(CMD_NOP, rq(), rq(), rq(), rq(), norm_pair());
		queue_pass(CMD_ADD, 64, {32'sh10000, 32'sh8000});
		queue_pass(CMD_DOT, 64, 64'd0);
		queue_pass(CMD_APPLY, 64, 64'd0);
		settle();

		// fill every slot over the short lengths used from here on
		set_cfg(REG_VECTOR_LENGTH, 16);
		set_cfg(REG_MAX_DIRECTIONS, 16);
		repeat (15) queue_pass(CMD_ADD, 16, norm_pair());
		queue_pass(CMD_DOT, 16, 64'd0);
		queue_pass(CMD_APPLY, 16, 64'd0);
		settle();

		// zero length, full store overwritten with a zero norm
		set_cfg(REG_VECTOR_LENGTH, 0);
		queue_pass(CMD_ADD, 1, 64'd0);
		queue_pass(CMD_DOT, 1, 64'd0);
		queue_pass(CMD_APPLY, 1, 64'd0);
		push(CMD_APPLY, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 64'd0);
		settle();

		// zero capacity, abandoned dot, apply after an add
		set_cfg(REG_VECTOR_LENGTH, 4);
		set_cfg(REG_MAX_DIRECTIONS, 0);
		queue_pass(CMD_DOT, 2, 64'd0);
		queue_pass(CMD_APPLY, 4, 64'd0);
		queue_pass(CMD_ADD, 4, norm_pair());
		queue_pass(CMD_APPLY, 4, 64'd0);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					set_cfg(REG_VECTOR_LENGTH, 16);
					set_cfg(REG_MAX_DIRECTIONS, 31);
				end
				1: begin
					set_cfg(REG_VECTOR_LENGTH, 1);
					set_cfg(REG_MAX_DIRECTIONS, 1);
				end
				2: begin
					set_cfg(REG_VECTOR_LENGTH, 7);
					set_cfg(REG_MAX_DIRECTIONS, 16);
				end
				default: begin
					k = $urandom_range(0, 17);
					set_cfg(REG_VECTOR_LENGTH, $urandom_range(0, 16));
					set_cfg(REG_MAX_DIRECTIONS, k == 17 ? 31 : k);
				end
			endcase
			if (ph == 7)
				quiet = 1;
			eff = vlen == 0 ? 1 : vlen;
			budget = 0;
			while (budget < 150) begin
				k = $urandom_range(0, 19);
				if (k <= 12) begin
					queue_pass(CMD_ADD, eff, norm_pair());
					queue_pass(CMD_DOT, eff, 64'd0);
					queue_pass(CMD_APPLY, eff, 64'd0);
					budget += 3 * eff;
				end else if (k <= 15) begin
					queue_pass(2'($urandom_range(0, 2)), eff, norm_pair());
					budget += eff;
				end else if (k <= 18) begin
					c1 = 2'($urandom_range(0, 2));
					c2 = 2'((c1 + $urandom_range(1, 2)) % 3);
					k = $urandom_range(1, eff);
					queue_pass(c1, k, norm_pair());
					queue_pass(c2, eff, norm_pair());
					budget += k + eff;
				end else begin
					push(CMD_NOP, rq(), rq(), rq(), rq(), norm_pair());
				end
				if (ph == 3 && budget >= 100 && budget < 110)
					settle();
			end
			settle();
		end

		$display("Sent %0d items and checked %0d results over %0d register writes,",
			items_sent, results_checked, settings_used);
		$display("covering add, dot and apply passes, abandoned passes and zero norms.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#400_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
